// ----- sv/drt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range table package
// Shared sizes, command and status codes, and controller interface types.
// ----------------------------------------------------------------------------
package drt_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int CNTR_W = (CNT_W > 7) ? CNT_W : 7;

   localparam logic [2:0] CMD_INSERT  = 3'd0;
   localparam logic [2:0] CMD_REPLACE = 3'd1;
   localparam logic [2:0] CMD_REMOVE  = 3'd2;
   localparam logic [2:0] CMD_EXTRACT = 3'd3;
   localparam logic [2:0] CMD_LOOKUP  = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERLAP  = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;
      logic out_busy;
   } ctl_sts_type;

endpackage

// ----- sv/drt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range table controller
// Sequences capture, table scan, drain of the compare stage and commit.
// ----------------------------------------------------------------------------
module drt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  drt_pkg::ctl_sts_type sts,
   output drt_pkg::ctl_cmd_type cmd
);
   import drt_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DRAIN  = 2'd2;
   localparam logic [1:0] S_COMMIT = 2'd3;

   logic [1:0] state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd.start  = 1'b0;
      cmd.scan   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (!sts.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ----- sv/drt_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range table datapath
// Range memories, valid bits, scan compare stage, commit logic and output word.
// ----------------------------------------------------------------------------
module drt_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  drt_pkg::ctl_cmd_type cmd,
   output drt_pkg::ctl_sts_type sts,
   input  logic [2:0]           req_cmd,
   input  logic [31:0]          req_lower_bound,
   input  logic [31:0]          req_upper_bound,
   input  logic [31:0]          req_lookup_key,
   input  logic [31:0]          req_data_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic                 rsp_hit,
   output logic [31:0]          rsp_data_out,
   output logic [6:0]           rsp_entries_used
);
   import drt_pkg::*;

   // Table storage.
   logic [31:0] low_mem  [TABLE_ENTRIES];
   logic [31:0] high_mem [TABLE_ENTRIES];
   logic [31:0] data_mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] slot_valid_ff, slot_valid_in;
   logic [CNTR_W-1:0] count_ff, count_in;

   // Captured command word.
   logic [2:0]  op_ff;
   logic [31:0] lo_ff, hi_ff, key_ff, val_ff;

   // Scan address and read stage.
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [31:0] rd_low_ff, rd_high_ff, rd_data_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic s1_vld_ff, s1_slotv_ff;

   // Scan results.
   logic ovl_ff, exact_ff, look_ff, free_ff;
   logic [IDX_W-1:0] exact_idx_ff, free_idx_ff;
   logic [31:0] exact_data_ff, look_data_ff;

   // Output word.
   logic rsp_valid_ff;
   logic [1:0] status_ff;
   logic hit_ff;
   logic [31:0] dout_ff;
   logic [6:0] used_ff;

   assign sts.scan_last = (idx_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign sts.out_busy  = rsp_valid_ff && rsp_stall;

   assign idx_in = cmd.start ? '0 : (cmd.scan ? idx_ff + 1'b1 : idx_ff);

   // Capture the command and step the scan address.
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.start) begin
         op_ff  <= req_cmd;
         lo_ff  <= req_lower_bound;
         hi_ff  <= req_upper_bound;
         key_ff <= req_lookup_key;
         val_ff <= req_data_value;
      end
   end

   // Registered memory read, one slot a cycle.
   always_ff @(posedge clock) begin
      rd_low_ff   <= low_mem[idx_ff];
      rd_high_ff  <= high_mem[idx_ff];
      rd_data_ff  <= data_mem[idx_ff];
      s1_idx_ff   <= idx_ff;
      s1_slotv_ff <= slot_valid_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else       s1_vld_ff <= cmd.scan;
   end

   // Compare the slot read last cycle against the command range and key.
   logic c_ovl, c_exact, c_look, c_free;
   always_comb begin
      c_ovl   = s1_vld_ff && s1_slotv_ff &&
                !(hi_ff < rd_low_ff) && !(rd_high_ff < lo_ff);
      c_exact = c_ovl && (rd_low_ff == lo_ff) && (rd_high_ff == hi_ff);
      c_look  = s1_vld_ff && s1_slotv_ff &&
                (key_ff >= rd_low_ff) && (key_ff <= rd_high_ff);
      c_free  = s1_vld_ff && !s1_slotv_ff;
   end

   // Keep the first match of each kind.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         ovl_ff   <= 1'b0;
         exact_ff <= 1'b0;
         look_ff  <= 1'b0;
         free_ff  <= 1'b0;
      end else begin
         if (c_ovl) ovl_ff <= 1'b1;
         if (c_exact && !exact_ff) begin
            exact_ff      <= 1'b1;
            exact_idx_ff  <= s1_idx_ff;
            exact_data_ff <= rd_data_ff;
         end
         if (c_look && !look_ff) begin
            look_ff      <= 1'b1;
            look_data_ff <= rd_data_ff;
         end
         if (c_free && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= s1_idx_ff;
         end
      end
   end

   // Decide the outcome from the scan results.
   logic [1:0]  d_status;
   logic        d_hit;
   logic [31:0] d_dout;
   logic        wr_all, wr_data, clr_valid;
   logic [IDX_W-1:0] wr_idx;
   always_comb begin
      d_status  = ST_OK;
      d_hit     = 1'b0;
      d_dout    = '0;
      wr_all    = 1'b0;
      wr_data   = 1'b0;
      clr_valid = 1'b0;
      wr_idx    = free_idx_ff;
      if (op_ff <= CMD_EXTRACT) begin
         priority if (lo_ff > hi_ff) begin
            d_status = (op_ff <= CMD_REPLACE) ? ST_OVERLAP : ST_NOTFOUND;
         end else if (op_ff == CMD_REPLACE && exact_ff) begin
            d_hit   = 1'b1;
            d_dout  = exact_data_ff;
            wr_data = 1'b1;
            wr_idx  = exact_idx_ff;
         end else if (op_ff <= CMD_REPLACE) begin
            priority if (ovl_ff)   d_status = ST_OVERLAP;
            else if (!free_ff)     d_status = ST_FULL;
            else                   wr_all   = 1'b1;
         end else begin
            priority if (exact_ff) begin
               d_hit     = 1'b1;
               d_dout    = exact_data_ff;
               clr_valid = 1'b1;
               wr_idx    = exact_idx_ff;
            end else if (ovl_ff) begin
               d_status = ST_OVERLAP;
            end else begin
               d_status = ST_NOTFOUND;
            end
         end
      end else if (op_ff == CMD_LOOKUP) begin
         if (look_ff) begin
            d_hit  = 1'b1;
            d_dout = look_data_ff;
         end else begin
            d_status = ST_NOTFOUND;
         end
      end
   end

   // Valid bits and count after the commit.
   always_comb begin
      slot_valid_in = slot_valid_ff;
      count_in      = count_ff;
      if (cmd.commit && wr_all) begin
         slot_valid_in[wr_idx] = 1'b1;
         count_in              = count_ff + 1'b1;
      end else if (cmd.commit && clr_valid) begin
         slot_valid_in[wr_idx] = 1'b0;
         count_in              = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         count_ff      <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         count_ff      <= count_in;
      end
   end

   // Memory writes.
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_all) begin
         low_mem[wr_idx]  <= lo_ff;
         high_mem[wr_idx] <= hi_ff;
      end
      if (cmd.commit && (wr_all || wr_data)) data_mem[wr_idx] <= val_ff;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= d_status;
         hit_ff    <= d_hit;
         dout_ff   <= d_dout;
         used_ff   <= count_in[6:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_data_out     = dout_ff;
   assign rsp_entries_used = used_ff;

endmodule

// ----- sv/disjoint_range_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disjoint range table
// Table of disjoint closed ranges with insert, replace, remove, extract and
// lookup commands, scanned one slot per cycle.
// ----------------------------------------------------------------------------
// Channel   Direction   Handshake            Word
// req_      in          req_valid/req_stall  cmd, bounds, key, data value
// rsp_      out         rsp_valid/rsp_stall  status, hit, data out, count
//
// Each command runs in order through a capture, a scan of every slot through
// the single memory read port, a drain of the compare stage and a commit. Reset
// clears the valid bits and the count at once. A stalled result sits in the
// output register; the next command still runs, and only its commit waits
// for the register to free.
// ----------------------------------------------------------------------------
module disjoint_range_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [31:0] req_lower_bound,
   input  logic [31:0] req_upper_bound,
   input  logic [31:0] req_lookup_key,
   input  logic [31:0] req_data_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_hit,
   output logic [31:0] rsp_data_out,
   output logic [6:0]  rsp_entries_used
);
   import drt_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   drt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   drt_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_cmd          (req_cmd),
      .req_lower_bound  (req_lower_bound),
      .req_upper_bound  (req_upper_bound),
      .req_lookup_key   (req_lookup_key),
      .req_data_value   (req_data_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_hit          (rsp_hit),
      .rsp_data_out     (rsp_data_out),
      .rsp_entries_used (rsp_entries_used)
   );

endmodule

// ----- sv/drt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range table port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module drt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic        rsp_hit,
   input logic [31:0] rsp_data_out,
   input logic [6:0]  rsp_entries_used
);
   import drt_pkg::*;

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_out)
         && $stable(rsp_status))
      else $error("stalled result changed");

   // Data out is zero without a hit.
   a_no_hit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_data_out == 32'd0)
      else $error("data out without hit");

   // Only an ok status carries a hit.
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_status == ST_OK)
      else $error("hit with error status");

   // One command at a time: an accepted word stalls the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted during a scan");

   // The count never exceeds the table size.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (TABLE_ENTRIES > 127) ||
         (rsp_entries_used <= 7'(TABLE_ENTRIES)))
      else $error("entry count out of range");

endmodule

bind disjoint_range_table drt_checker u_drt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_hit          (rsp_hit),
   .rsp_data_out     (rsp_data_out),
   .rsp_entries_used (rsp_entries_used)
);

// ----- bench/disjoint_range_table_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disjoint range table testbench
// Drives range commands through the request channel and checks every result
// word against a predictor that keeps its own copy of the range table.
// ----------------------------------------------------------------------------
module disjoint_range_table_test;
   import drt_pkg::*;

   localparam int NUM_ITEMS = 550;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] lower_bound;
      logic [31:0] upper_bound;
      logic [31:0] lookup_key;
      logic [31:0] data_value;
   } req_word_t;

   typedef struct packed {
      logic [1:0]  status;
      logic        hit;
      logic [31:0] data_out;
      logic [6:0]  entries_used;
   } rsp_word_t;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_cmd;
   logic [31:0] req_lower_bound;
   logic [31:0] req_upper_bound;
   logic [31:0] req_lookup_key;
   logic [31:0] req_data_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic        rsp_hit;
   logic [31:0] rsp_data_out;
   logic [6:0]  rsp_entries_used;

   disjoint_range_table dut (.*);

   // Predictor copy of the table.
   logic [31:0] model_low [TABLE_ENTRIES];
   logic [31:0] model_high[TABLE_ENTRIES];
   logic [31:0] model_data[TABLE_ENTRIES];
   logic        model_valid[TABLE_ENTRIES];
   int          model_count;

   req_word_t pending_words[$];
   rsp_word_t expected_words[$];
   int        error_count;
   int        send_idle_pct;
   int        recv_stall_pct;
   bit        stim_done;
   bit        req_accepted;

   // Ranges sent with insert and replace commands, kept for aiming later commands at them.
   logic [31:0] live_lo[$];
   logic [31:0] live_hi[$];

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   // Work out the result of one command and update the table copy.
   function automatic rsp_word_t predict_range_command(input req_word_t w);
      rsp_word_t r;
      int        ovl;
      int        exact;
      int        slot;
      r = '0;
      r.status = ST_OK;
      ovl = -1;
      exact = -1;
      slot = -1;
      if (w.cmd <= CMD_EXTRACT) begin
         if (w.lower_bound > w.upper_bound) begin
            r.status = (w.cmd <= CMD_REPLACE) ? ST_OVERLAP : ST_NOTFOUND;
         end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (model_valid[i] && !(w.upper_bound < model_low[i]) &&
                   !(model_high[i] < w.lower_bound)) begin
                  if (ovl < 0) ovl = i;
                  if (exact < 0 && model_low[i] == w.lower_bound &&
                      model_high[i] == w.upper_bound) exact = i;
               end
            end
            if (w.cmd == CMD_REPLACE && exact >= 0) begin
               r.hit = 1'b1;
               r.data_out = model_data[exact];
               model_data[exact] = w.data_value;
            end else if (w.cmd <= CMD_REPLACE) begin
               if (ovl >= 0) begin
                  r.status = ST_OVERLAP;
               end else begin
                  for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                     if (!model_valid[i]) slot = i;
                  if (slot < 0) begin
                     r.status = ST_FULL;
                  end else begin
                     model_low[slot] = w.lower_bound;
                     model_high[slot] = w.upper_bound;
                     model_data[slot] = w.data_value;
                     model_valid[slot] = 1'b1;
                     model_count++;
                  end
               end
            end else if (exact >= 0) begin
               r.hit = 1'b1;
               r.data_out = model_data[exact];
               model_valid[exact] = 1'b0;
               if (model_count > 0) model_count--;
            end else begin
               r.status = (ovl >= 0) ? ST_OVERLAP : ST_NOTFOUND;
            end
         end
      end else if (w.cmd == CMD_LOOKUP) begin
         r.status = ST_NOTFOUND;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (r.hit == 1'b0 && model_valid[i] && w.lookup_key >= model_low[i] &&
                w.lookup_key <= model_high[i]) begin
               r.status = ST_OK;
               r.hit = 1'b1;
               r.data_out = model_data[i];
            end
         end
      end
      r.entries_used = model_count[6:0];
      return r;
   endfunction

   function automatic req_word_t make_word(input logic [2:0] cmd, input logic [31:0] lo,
                                           input logic [31:0] hi, input logic [31:0] key,
                                           input logic [31:0] val);
      req_word_t w;
      w.cmd = cmd;
      w.lower_bound = lo;
      w.upper_bound = hi;
      w.lookup_key = key;
      w.data_value = val;
      return w;
   endfunction

   // Random command, mostly aimed at ranges sent before or at small sparse ranges.
   function automatic req_word_t random_word();
      req_word_t   w;
      int          pick;
      int          j;
      logic [31:0] base;
      w = make_word(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom);
      pick = $urandom_range(0, 99);
      if (live_lo.size() > 0 && pick < 45) begin
         j = $urandom_range(0, live_lo.size() - 1);
         w.lower_bound = live_lo[j];
         w.upper_bound = live_hi[j];
         w.lookup_key = live_lo[j] + $urandom_range(0, 3);
         if (pick < 8) w.lower_bound = live_lo[j] + 1;
      end else if (pick < 90) begin
         base = {8'($urandom_range(0, 255)), 24'h0} | 32'($urandom_range(0, 4095));
         w.lower_bound = base;
         w.upper_bound = base + $urandom_range(0, 5000);
         w.lookup_key = base + $urandom_range(0, 6000);
      end
      if (w.cmd <= CMD_REPLACE && w.lower_bound <= w.upper_bound) begin
         live_lo.push_back(w.lower_bound);
         live_hi.push_back(w.upper_bound);
      end
      return w;
   endfunction

   // Driver: presents pending words, changing inputs at the falling edge.
   // A word is held until the rising edge that accepts it.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_word_t w;
            w = pending_words.pop_front();
            req_valid <= 1'b1;
            {req_cmd, req_lower_bound, req_upper_bound, req_lookup_key,
             req_data_value} <= w;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Request monitor: predicts each accepted word at the rising edge.
   always @(posedge clock) begin
      req_accepted <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall)
         expected_words.push_back(predict_range_command({req_cmd, req_lower_bound,
            req_upper_bound, req_lookup_key, req_data_value}));
   end

   // Result monitor: compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected result word", 32'd1, 32'd0);
         end else begin
            rsp_word_t e;
            e = expected_words.pop_front();
            if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
            if (rsp_hit !== e.hit) report_mismatch("hit", rsp_hit, e.hit);
            if (rsp_data_out !== e.data_out)
               report_mismatch("data_out", rsp_data_out, e.data_out);
            if (rsp_entries_used !== e.entries_used)
               report_mismatch("entries_used", rsp_entries_used, e.entries_used);
         end
      end
   end

   task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) pending_words.push_back(random_word());
      wait (pending_words.size() == 0);
   endtask

   initial begin
      error_count = 0;
      stim_done = 0;
      req_accepted = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_stall = 1'b0;
      {req_cmd, req_lower_bound, req_upper_bound, req_lookup_key, req_data_value} = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         model_valid[i] = 1'b0;
         model_low[i] = '0;
         model_high[i] = '0;
         model_data[i] = '0;
      end
      model_count = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes, every command, inverted ranges, unused codes.
      pending_words.push_back(make_word(CMD_LOOKUP, 0, 0, 32'h0, 0));
      pending_words.push_back(make_word(CMD_REMOVE, 5, 9, 0, 0));
      pending_words.push_back(make_word(CMD_INSERT, 32'h0, 32'h0, 0, 32'hFFFFFFFF));
      pending_words.push_back(make_word(CMD_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 1));
      pending_words.push_back(make_word(CMD_INSERT, 32'h0, 32'h0, 0, 2));
      pending_words.push_back(make_word(CMD_INSERT, 100, 200, 0, 32'hA5A5A5A5));
      pending_words.push_back(make_word(CMD_INSERT, 150, 300, 0, 3));
      pending_words.push_back(make_word(CMD_INSERT, 20, 10, 0, 4));
      pending_words.push_back(make_word(CMD_REPLACE, 20, 10, 0, 4));
      pending_words.push_back(make_word(CMD_EXTRACT, 20, 10, 0, 4));
      pending_words.push_back(make_word(CMD_LOOKUP, 0, 0, 32'd150, 0));
      pending_words.push_back(make_word(CMD_LOOKUP, 0, 0, 32'hFFFFFFFF, 0));
      pending_words.push_back(make_word(CMD_LOOKUP, 0, 0, 32'd201, 0));
      pending_words.push_back(make_word(CMD_REPLACE, 100, 200, 0, 32'h5A5A5A5A));
      pending_words.push_back(make_word(CMD_REPLACE, 150, 250, 0, 5));
      pending_words.push_back(make_word(CMD_REPLACE, 400, 500, 0, 6));
      pending_words.push_back(make_word(CMD_REMOVE, 100, 150, 0, 0));
      pending_words.push_back(make_word(CMD_REMOVE, 100, 200, 0, 0));
      pending_words.push_back(make_word(CMD_EXTRACT, 400, 500, 0, 0));
      pending_words.push_back(make_word(CMD_EXTRACT, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0));
      pending_words.push_back(make_word(3'd5, 1, 2, 3, 4));
      pending_words.push_back(make_word(3'd7, 32'hFFFFFFFF, 0, 32'hFFFFFFFF, 0));
      pending_words.push_back(make_word(CMD_INSERT, 32'h0, 32'hFFFFFFFF, 0, 7));
      // Fill the table to full, then probe full on insert and replace.
      for (int i = 0; i < TABLE_ENTRIES; i++)
         pending_words.push_back(make_word(CMD_INSERT, 32'h10000 * (i + 1),
            32'h10000 * (i + 1) + 16, 0, $urandom));
      pending_words.push_back(make_word(CMD_INSERT, 32'h7000000, 32'h7000001, 0, 8));
      pending_words.push_back(make_word(CMD_REPLACE, 32'h7000000, 32'h7000001, 0, 9));
      for (int i = 0; i < TABLE_ENTRIES; i += 2)
         pending_words.push_back(make_word(CMD_REMOVE, 32'h10000 * (i + 1),
            32'h10000 * (i + 1) + 16, 0, 0));
      wait (pending_words.size() == 0);

      run_phase(0, 0, 110);
      run_phase(48, 0, 110);
      run_phase(0, 48, 105);
      run_phase(33, 33, 105);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait (!req_valid && expected_words.size() == 0);
      repeat (3 * (TABLE_ENTRIES + 3)) @(posedge clock);
      if (error_count == 0)
         $display("disjoint_range_table_test passed");
      else
         $display("disjoint_range_table_test failed");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(12 * 400000);
      $display("disjoint_range_table_test failed");
      $finish;
   end

endmodule
